@@ rtl/gimv_pkg.sv @@
// Shared types and constants for the grouped int8 matrix-vector row block.
package gimv_pkg;

  // Input word command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GROUP_SIZE = 2'd0;
  localparam logic [1:0] CFG_ROW_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT  = 2'd2;

  // Field widths
  localparam int GS_W     = 9;
  localparam int LEN_REGW = 13;
  localparam int ROWS_W   = 17;
  localparam int CFG_W    = 17;
  localparam int SCALE_W  = 32;
  localparam int SUM_W    = 24;
  localparam int ACC_W    = 64;
  localparam int OFF_W    = 8;
  localparam int DONE_W   = 16;

  // Reset values of the configuration registers
  localparam logic [GS_W-1:0]     GS_RESET   = 9'd64;
  localparam logic [LEN_REGW-1:0] LEN_RESET  = 13'd256;
  localparam logic [ROWS_W-1:0]   ROWS_RESET = 17'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FACT,
    ST_PROD,
    ST_ACC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept_load;
    logic accept_weight;
    logic do_mul;
    logic do_fact;
    logic do_prod;
    logic do_acc;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic grp_end;
  } dp_stat_t;

endpackage

@@ rtl/grouped_int8_matvec_row.sv @@
// Top level of the grouped int8 matrix-vector row engine.
// Load words are taken while idle; weight words pass a store read, then a multiply into group sum;
// a word that closes a group goes on through scale product, rounding, term and accumulate.
// A row result is on the out ports for one cycle, registered at the accumulate step that
// follows the row's last weight word; the receiver cannot stall it.
// Sync active-low reset restores default config and clears run state, not the stores.
module grouped_int8_matvec_row #(
  parameter int MAX_LEN    = 4096,
  parameter int MAX_GROUPS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic signed [7:0]            in_value,
  input  logic [gimv_pkg::SCALE_W-1:0] in_scale,
  output logic                         out_valid,
  output logic signed [gimv_pkg::ACC_W-1:0] out_row_value,
  output logic                         out_last_row,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [gimv_pkg::CFG_W-1:0]   cfg_data
);

  gimv_pkg::ctrl_cmd_t cmd;
  gimv_pkg::dp_stat_t  stat;

  // config words are taken whenever no weight word is in flight
  assign cfg_ready = ~busy;

  gimv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  gimv_dp #(
    .MAX_LEN    (MAX_LEN),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value      (in_value),
    .in_scale      (in_scale),
    .out_valid     (out_valid),
    .out_row_value (out_row_value),
    .out_last_row  (out_last_row)
  );

endmodule

@@ rtl/gimv_ram.sv @@
// Generic simple dual-port RAM with registered read.
module gimv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gimv_ctrl.sv @@
// Controller state machine sequencing load and weight words.
module gimv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_cmd,
  input  gimv_pkg::dp_stat_t    stat,
  output gimv_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  gimv_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gimv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gimv_pkg::ST_IDLE: begin
        if (start && in_cmd == gimv_pkg::CMD_WEIGHT) begin
          state_nxt = gimv_pkg::ST_MUL;
        end
      end
      gimv_pkg::ST_MUL: begin
        state_nxt = stat.grp_end ? gimv_pkg::ST_FACT : gimv_pkg::ST_IDLE;
      end
      gimv_pkg::ST_FACT: state_nxt = gimv_pkg::ST_PROD;
      gimv_pkg::ST_PROD: state_nxt = gimv_pkg::ST_ACC;
      gimv_pkg::ST_ACC:  state_nxt = gimv_pkg::ST_IDLE;
      default:           state_nxt = gimv_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      gimv_pkg::ST_IDLE: begin
        busy              = 1'b0;
        cmd.accept_load   = start && (in_cmd == gimv_pkg::CMD_LOAD);
        cmd.accept_weight = start && (in_cmd == gimv_pkg::CMD_WEIGHT);
      end
      gimv_pkg::ST_MUL:  cmd.do_mul  = 1'b1;
      gimv_pkg::ST_FACT: cmd.do_fact = 1'b1;
      gimv_pkg::ST_PROD: cmd.do_prod = 1'b1;
      gimv_pkg::ST_ACC:  cmd.do_acc  = 1'b1;
      default:           busy        = 1'b1;
    endcase
  end

endmodule

@@ rtl/gimv_dp.sv @@
// Datapath: config registers, position counters, stores and arithmetic.
module gimv_dp #(
  parameter int MAX_LEN    = 4096,
  parameter int MAX_GROUPS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gimv_pkg::ctrl_cmd_t          cmd,
  output gimv_pkg::dp_stat_t           stat,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [gimv_pkg::CFG_W-1:0]   cfg_data,
  input  logic signed [7:0]            in_value,
  input  logic [gimv_pkg::SCALE_W-1:0] in_scale,
  output logic                         out_valid,
  output logic signed [gimv_pkg::ACC_W-1:0] out_row_value,
  output logic                         out_last_row
);

  localparam int POS_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int GRP_CNT = (MAX_LEN + 15) / 16;
  localparam int GRP_W   = (GRP_CNT > 1) ? $clog2(GRP_CNT) : 1;
  localparam int SA_W    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int ACC_W   = gimv_pkg::ACC_W;
  localparam int SUM_W   = gimv_pkg::SUM_W;

  // configuration registers
  logic [gimv_pkg::GS_W-1:0]     gs_r;
  logic [gimv_pkg::LEN_REGW-1:0] len_r;
  logic [gimv_pkg::ROWS_W-1:0]   rows_r;
  logic                          cfg_hit;

  // run state
  logic [POS_W-1:0]           ld_pos_r, wt_pos_r;
  logic [gimv_pkg::OFF_W-1:0] ld_off_r, wt_off_r;
  logic [GRP_W-1:0]           ld_grp_r, wt_grp_r;
  logic [gimv_pkg::DONE_W-1:0] rows_done_r;
  logic signed [SUM_W-1:0]    gsum_r;
  logic signed [ACC_W-1:0]    acc_r;

  // per-word latches and pipeline registers
  logic signed [7:0]            val_r;
  logic [gimv_pkg::SCALE_W-1:0] sc_r;
  logic                         grp_end_r, row_end_r, grp_ok_r;
  logic [63:0]                  sp_r;
  logic [31:0]                  f_r;
  logic signed [56:0]           term_r;

  // output registers
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  out_row_value_r;
  logic                     out_last_row_r;

  // effective (clamped) configuration
  logic [gimv_pkg::GS_W-1:0]   eff_gs;
  logic [LEN_W-1:0]            eff_len;
  logic [gimv_pkg::ROWS_W-1:0] eff_rows;

  always_comb begin
    if (gs_r < 9'd16) begin
      eff_gs = 9'd16;
    end else if (gs_r > 9'd256) begin
      eff_gs = 9'd256;
    end else begin
      eff_gs = gs_r;
    end
    if (32'(len_r) < 32'd16) begin
      eff_len = LEN_W'(16);
    end else if (32'(len_r) > 32'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(len_r);
    end
    if (rows_r == '0) begin
      eff_rows = 17'd1;
    end else if (rows_r > 17'd65536) begin
      eff_rows = 17'd65536;
    end else begin
      eff_rows = rows_r;
    end
  end

  // position decode for both counters
  logic ld_row_end, ld_grp_end, wt_row_end, wt_grp_end, ld_grp_ok, wt_grp_ok;

  assign ld_row_end = (32'(ld_pos_r) + 32'd1) == 32'(eff_len);
  assign wt_row_end = (32'(wt_pos_r) + 32'd1) == 32'(eff_len);
  assign ld_grp_end = ld_row_end || ((9'(ld_off_r) + 9'd1) == eff_gs);
  assign wt_grp_end = wt_row_end || ((9'(wt_off_r) + 9'd1) == eff_gs);
  assign ld_grp_ok  = 32'(ld_grp_r) < 32'(MAX_GROUPS);
  assign wt_grp_ok  = 32'(wt_grp_r) < 32'(MAX_GROUPS);

  // config write decode
  always_comb begin
    unique case (cfg_index) inside
      gimv_pkg::CFG_GROUP_SIZE,
      gimv_pkg::CFG_ROW_LENGTH,
      gimv_pkg::CFG_ROW_COUNT: cfg_hit = cfg_we;
      default:                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r   <= gimv_pkg::GS_RESET;
      len_r  <= gimv_pkg::LEN_RESET;
      rows_r <= gimv_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gimv_pkg::CFG_GROUP_SIZE: gs_r   <= cfg_data[gimv_pkg::GS_W-1:0];
        gimv_pkg::CFG_ROW_LENGTH: len_r  <= cfg_data[gimv_pkg::LEN_REGW-1:0];
        gimv_pkg::CFG_ROW_COUNT:  rows_r <= cfg_data[gimv_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // activation and activation scale stores
  logic signed [7:0]            act_q;
  logic [gimv_pkg::SCALE_W-1:0] as_q;
  logic [7:0]                   act_raw;

  gimv_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_act_ram (
    .clk   (clk),
    .we    (cmd.accept_load),
    .waddr (ld_pos_r),
    .wdata (in_value),
    .re    (cmd.accept_weight),
    .raddr (wt_pos_r),
    .rdata (act_raw)
  );

  assign act_q = act_raw;

  gimv_ram #(.WIDTH(gimv_pkg::SCALE_W), .DEPTH(MAX_GROUPS)) u_scale_ram (
    .clk   (clk),
    .we    (cmd.accept_load && ld_grp_end && ld_grp_ok),
    .waddr (SA_W'(ld_grp_r)),
    .wdata (in_scale),
    .re    (cmd.accept_weight),
    .raddr (SA_W'(wt_grp_r)),
    .rdata (as_q)
  );

  // arithmetic
  logic signed [15:0]       prod;
  logic signed [SUM_W-1:0]  gsum_add;
  logic [63:0]              sp;
  logic [63:0]              sp_rnd;
  logic [31:0]              f_sat;
  logic signed [56:0]       term;
  logic signed [ACC_W-1:0]  term_ext, acc_sum, acc_sat;
  logic                     last;

  assign prod     = 16'(val_r) * 16'(act_q);
  assign gsum_add = gsum_r + {{(SUM_W-16){prod[15]}}, prod};
  assign sp       = 64'(sc_r) * 64'(grp_ok_r ? as_q : 32'd0);
  assign sp_rnd   = sp_r + 64'h0000_0000_0080_0000;
  assign f_sat    = (|sp_rnd[63:56]) ? 32'hFFFF_FFFF : sp_rnd[55:24];
  assign term     = 57'($signed({1'b0, f_r})) * 57'(gsum_r);
  assign term_ext = {{(ACC_W-57){term_r[56]}}, term_r};
  assign acc_sum  = acc_r + term_ext;

  // saturate on signed overflow
  always_comb begin
    if (acc_r[ACC_W-1] == term_ext[ACC_W-1] && acc_sum[ACC_W-1] != acc_r[ACC_W-1]) begin
      acc_sat = term_ext[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum;
    end
  end

  assign last = (17'(rows_done_r) + 17'd1) >= eff_rows;

  // control-bearing run state
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      ld_pos_r    <= '0;
      ld_off_r    <= '0;
      ld_grp_r    <= '0;
      wt_pos_r    <= '0;
      wt_off_r    <= '0;
      wt_grp_r    <= '0;
      rows_done_r <= '0;
      gsum_r      <= '0;
      acc_r       <= '0;
    end else begin
      if (cmd.accept_load) begin
        ld_pos_r <= ld_row_end ? '0 : ld_pos_r + 1'b1;
        ld_off_r <= ld_grp_end ? '0 : ld_off_r + 1'b1;
        ld_grp_r <= ld_row_end ? '0 : (ld_grp_end ? ld_grp_r + 1'b1 : ld_grp_r);
      end
      if (cmd.accept_weight) begin
        wt_pos_r <= wt_row_end ? '0 : wt_pos_r + 1'b1;
        wt_off_r <= wt_grp_end ? '0 : wt_off_r + 1'b1;
        wt_grp_r <= wt_row_end ? '0 : (wt_grp_end ? wt_grp_r + 1'b1 : wt_grp_r);
      end
      if (cmd.do_mul) begin
        gsum_r <= gsum_add;
      end
      if (cmd.do_acc) begin
        gsum_r <= '0;
        if (row_end_r) begin
          acc_r       <= '0;
          rows_done_r <= last ? '0 : rows_done_r + 1'b1;
        end else begin
          acc_r <= acc_sat;
        end
      end
    end
  end

  // per-word payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept_weight) begin
      val_r     <= in_value;
      sc_r      <= in_scale;
      grp_end_r <= wt_grp_end;
      row_end_r <= wt_row_end;
      grp_ok_r  <= wt_grp_ok;
    end
    if (cmd.do_mul) begin
      sp_r <= sp;
    end
    if (cmd.do_fact) begin
      f_r <= f_sat;
    end
    if (cmd.do_prod) begin
      term_r <= term;
    end
    if (cmd.do_acc) begin
      out_row_value_r <= acc_sat;
      out_last_row_r  <= last;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.do_acc && row_end_r;
    end
  end

  assign stat.grp_end  = grp_end_r;
  assign out_valid     = out_valid_r;
  assign out_row_value = out_row_value_r;
  assign out_last_row  = out_last_row_r;

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the grouped int8 matrix-vector row engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 4096;
  localparam int MAX_GROUPS = 256;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [gimv_pkg::SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;

  typedef logic [gimv_pkg::CFG_W-1:0]   cfg_word_t;
  typedef logic [gimv_pkg::SCALE_W-1:0] scale_t;

  typedef struct packed {
    logic signed [gimv_pkg::ACC_W-1:0] row_value;
    logic                              last_row;
  } row_word_t;

  // DUT signals, all inputs known from time zero
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_cmd = gimv_pkg::CMD_LOAD;
  logic signed [7:0]                 in_value = '0;
  scale_t                            in_scale = '0;
  logic                              out_valid;
  logic signed [gimv_pkg::ACC_W-1:0] out_row_value;
  logic                              out_last_row;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [1:0]                        cfg_index = '0;
  cfg_word_t                         cfg_data = '0;

  // Shadow copy of the engine's registers and state
  logic [gimv_pkg::GS_W-1:0]     gs_reg = gimv_pkg::GS_RESET;
  logic [gimv_pkg::LEN_REGW-1:0] len_reg = gimv_pkg::LEN_RESET;
  logic [gimv_pkg::ROWS_W-1:0]   rows_reg = gimv_pkg::ROWS_RESET;
  logic signed [7:0]             act_mem [MAX_LEN];
  scale_t                        act_scale_mem [MAX_GROUPS];
  int unsigned                   load_pos = 0;
  int unsigned                   weight_pos = 0;
  int unsigned                   rows_done = 0;
  int                            group_sum = 0;
  longint                        row_acc = 0;

  row_word_t                row_q[$];
  int                       errors = 0;
  int                       reports = 0;
  int                       words_sent = 0;
  int                       rows_predicted = 0;
  int                       idle_pct = 0;
  longint                   cycles = 0;

  grouped_int8_matvec_row #(
    .MAX_LEN    (MAX_LEN),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_scale      (in_scale),
    .out_valid     (out_valid),
    .out_row_value (out_row_value),
    .out_last_row  (out_last_row),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_group();
    return clamp_u(gs_reg, 16, 256);
  endfunction

  function automatic int unsigned eff_length();
    return clamp_u(len_reg, 16, MAX_LEN);
  endfunction

  function automatic int unsigned eff_rows();
    return clamp_u(rows_reg, 1, 65536);
  endfunction

  // Register write: valid indexes also restart the run state
  function automatic void apply_cfg(logic [1:0] idx, cfg_word_t data);
    case (idx)
      gimv_pkg::CFG_GROUP_SIZE: gs_reg = data[gimv_pkg::GS_W-1:0];
      gimv_pkg::CFG_ROW_LENGTH: len_reg = data[gimv_pkg::LEN_REGW-1:0];
      gimv_pkg::CFG_ROW_COUNT:  rows_reg = data[gimv_pkg::ROWS_W-1:0];
      default:                  return;
    endcase
    load_pos = 0;
    weight_pos = 0;
    group_sum = 0;
    row_acc = 0;
    rows_done = 0;
  endfunction

  // Dot-product predictor: updates shadow state, queues a row value at row end
  function automatic void predict_dot(logic cmd, logic signed [7:0] value, scale_t scale);
    int unsigned gs, len, pos, grp;
    bit row_end, grp_end, last;
    logic [64:0] prod;
    scale_t act_scale, factor;
    longint term, sum;
    gs = eff_group();
    len = eff_length();
    pos = (cmd == gimv_pkg::CMD_LOAD) ? load_pos : weight_pos;
    if (pos >= len) pos = 0;
    row_end = (pos + 1 == len);
    grp_end = row_end || ((pos + 1) % gs == 0);
    grp = pos / gs;
    if (cmd == gimv_pkg::CMD_LOAD) begin
      act_mem[pos] = value;
      if (grp_end && grp < MAX_GROUPS) act_scale_mem[grp] = scale;
      load_pos = row_end ? 0 : pos + 1;
      return;
    end
    group_sum += int'(value) * int'(act_mem[pos]);
    if (grp_end) begin
      // Q8.24 x Q8.24, round half up back to Q8.24, saturate to 32 bits
      act_scale = (grp < MAX_GROUPS) ? act_scale_mem[grp] : '0;
      prod = {33'd0, scale} * {33'd0, act_scale};
      prod = (prod + 65'd8388608) >> 24;
      factor = (prod > 65'h0_FFFF_FFFF) ? '1 : prod[gimv_pkg::SCALE_W-1:0];
      term = longint'(factor) * longint'(group_sum);
      sum = row_acc + term;
      if (term > 0 && sum < row_acc) sum = {1'b0, {63{1'b1}}};
      else if (term < 0 && sum > row_acc) sum = {1'b1, 63'd0};
      row_acc = sum;
      group_sum = 0;
    end
    weight_pos = row_end ? 0 : pos + 1;
    if (row_end) begin
      last = (rows_done + 1 >= eff_rows());
      row_q.push_back('{row_value: row_acc, last_row: last});
      rows_predicted++;
      row_acc = 0;
      rows_done = last ? 0 : rows_done + 1;
    end
  endfunction

  // Row result checker
  always @(posedge clk) begin
    row_word_t exp_w;
    if (rst_n && out_valid) begin
      if (row_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("unexpected row word: value %0d last %0b", out_row_value, out_last_row);
        end
      end else begin
        exp_w = row_q.pop_front();
        if (out_row_value !== exp_w.row_value || out_last_row !== exp_w.last_row) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("row mismatch: expected value %0d last %0b, got value %0d last %0b",
                     exp_w.row_value, exp_w.last_row, out_row_value, out_last_row);
          end
        end
      end
    end
  end

  function automatic logic signed [7:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return -8'sd128;
      1:       return 8'sd127;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic scale_t pick_scale();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return $urandom();
      default: return $urandom_range(32'h0000_8000, 32'h0200_0000);
    endcase
  endfunction

  // Send one input word; start stays high after acceptance
  task automatic send_word(logic cmd, logic signed [7:0] value, scale_t scale);
    // each cycle before the word is idle with probability idle_pct
    while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    in_scale <= scale;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_dot(cmd, value, scale);
    words_sent++;
  endtask

  // Hold off until every queued row word has come and the engine is quiet
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (row_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, cfg_word_t data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    apply_cfg(idx, data);
  endtask

  task automatic configure(cfg_word_t gs, cfg_word_t len, cfg_word_t rows);
    write_reg(gimv_pkg::CFG_GROUP_SIZE, gs);
    write_reg(gimv_pkg::CFG_ROW_LENGTH, len);
    write_reg(gimv_pkg::CFG_ROW_COUNT, rows);
  endtask

  task automatic load_vector();
    for (int i = 0; i < eff_length(); i++)
      send_word(gimv_pkg::CMD_LOAD, pick_value(), pick_scale());
  endtask

  // Weight rows with optional stray activation words mixed in
  task automatic stream_rows(int n_rows, int noise_pct);
    for (int r = 0; r < n_rows; r++) begin
      for (int i = 0; i < eff_length(); i++) begin
        if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
          send_word(gimv_pkg::CMD_LOAD, pick_value(), pick_scale());
        send_word(gimv_pkg::CMD_WEIGHT, pick_value(), pick_scale());
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
    end
  endtask

  task automatic run_job(cfg_word_t gs, cfg_word_t len, cfg_word_t rows,
                         int n_rows, int noise_pct);
    configure(gs, len, rows);
    load_vector();
    stream_rows(n_rows, noise_pct);
  endtask

  // Power-on register values: 64-wide groups, 256-long rows, one row
  task automatic test_default_config();
    load_vector();
    stream_rows(1, 0);
    wait_idle();
  endtask

  // Extreme int8 products with unit scales
  task automatic test_value_extremes();
    configure(16, 16, 2);
    for (int i = 0; i < 16; i++)
      send_word(gimv_pkg::CMD_LOAD, (i % 2) ? 8'sd127 : -8'sd128, SCALE_ONE);
    for (int i = 0; i < 16; i++) send_word(gimv_pkg::CMD_WEIGHT, -8'sd128, SCALE_ONE);
    for (int i = 0; i < 16; i++) send_word(gimv_pkg::CMD_WEIGHT, 8'sd127, SCALE_ONE);
  endtask

  // Exact half rounds up, just below half rounds down, factor saturation, zero scale
  task automatic test_scale_rounding();
    scale_t act_scales [4];
    scale_t wt_scales [4];
    act_scales = '{32'h0080_0000, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    wt_scales = '{32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    configure(16, 64, 1);
    for (int i = 0; i < 64; i++) send_word(gimv_pkg::CMD_LOAD, 8'sd1, act_scales[i / 16]);
    for (int i = 0; i < 64; i++)
      send_word(gimv_pkg::CMD_WEIGHT, (i / 16 == 2) ? -8'sd128 : 8'sd127, wt_scales[i / 16]);
  endtask

  // Trailing partial groups and groups wider than the row
  task automatic test_partial_groups();
    run_job(24, 40, 2, 2, 0);
    run_job(17'h1FFFF, 100, 1, 1, 0);
    run_job(48, 40, 1, 1, 0);
  endtask

  // Out-of-range register values are clamped
  task automatic test_register_clamps();
    run_job(5, 3, 0, 2, 0);
    run_job(17, 20, 17'h1FFFF, 3, 0);
    run_job(0, 40, 1, 1, 0);
  endtask

  // A register write drops a partial row but keeps the stores;
  // an unused index changes nothing
  task automatic test_config_clear();
    run_job(16, 32, 3, 0, 0);
    for (int i = 0; i < 20; i++) send_word(gimv_pkg::CMD_WEIGHT, pick_value(), pick_scale());
    write_reg(gimv_pkg::CFG_ROW_COUNT, 2);
    stream_rows(2, 0);
    for (int i = 0; i < 10; i++) send_word(gimv_pkg::CMD_LOAD, pick_value(), pick_scale());
    write_reg(CFG_UNUSED, cfg_word_t'($urandom()));
    for (int i = 10; i < 32; i++) send_word(gimv_pkg::CMD_LOAD, pick_value(), pick_scale());
    stream_rows(2, 0);
  endtask

  // Random jobs with random sizes, row wrap and stray words
  task automatic test_random(int pct, int n_words, int n_rows);
    int w_goal, r_goal;
    cfg_word_t gs, len, rows;
    int sent_rows;
    idle_pct = pct;
    w_goal = words_sent + n_words;
    r_goal = rows_predicted + n_rows;
    while (words_sent < w_goal || rows_predicted < r_goal) begin
      case ($urandom_range(0, 9))
        0:       gs = cfg_word_t'($urandom_range(0, 511));
        1:       gs = cfg_word_t'(256);
        default: gs = cfg_word_t'($urandom_range(16, 48));
      endcase
      case ($urandom_range(0, 9))
        0:       len = cfg_word_t'($urandom_range(0, 15));
        1:       len = cfg_word_t'($urandom_range(64, 128));
        default: len = cfg_word_t'($urandom_range(16, 64));
      endcase
      rows = ($urandom_range(0, 9) == 0) ? cfg_word_t'($urandom_range(0, 131071))
                                          : cfg_word_t'($urandom_range(1, 4));
      configure(gs, len, rows);
      load_vector();
      sent_rows = int'((eff_rows() < 3) ? eff_rows() : 3) + int'($urandom_range(0, 1));
      stream_rows(sent_rows, ($urandom_range(0, 2) == 0) ? 10 : 0);
      // sometimes leave a partial row for the next register write to drop
      if ($urandom_range(0, 2) == 0)
        for (int i = int'($urandom_range(1, eff_length() - 1)); i > 0; i--)
          send_word(gimv_pkg::CMD_WEIGHT, pick_value(), pick_scale());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_config();
    test_value_extremes();
    test_scale_rounding();
    test_partial_groups();
    test_register_clamps();
    test_config_clear();
    test_random(29, 100, 2);
    test_random(69, 100, 2);
    test_random(0, 100, 2);
    idle_pct = 0;
    wait_idle();
    if (errors == 0 && row_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
